[sv/gamepad_line_command_parser_unit_assert.svh]
// assertion macros for the gamepad line command parser
// used by the top level only; expects a clock named aclk and a reset named aresetn
`ifndef GAMEPAD_LINE_COMMAND_PARSER_UNIT_ASSERT_SVH
`define GAMEPAD_LINE_COMMAND_PARSER_UNIT_ASSERT_SVH

// property checked outside reset
`define GPCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked on every edge, reset included
`define GPCP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[sv/gpcp_pkg.sv]
// shared types and constants of the gamepad line command parser
// no dependencies
`default_nettype none

package gpcp_pkg;

    // line and button limits
    localparam int unsigned MAX_LINE     = 19;
    localparam int unsigned BUTTON_COUNT = 8;
    localparam int unsigned BTN_IDX_W    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int unsigned LINE_CNT_W   = $clog2(MAX_LINE + 1);

    // characters
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_N     = 8'h6E;

    // keyword compare progress
    localparam logic [3:0] KW_START = 4'd0;
    localparam logic [3:0] KW_A     = 4'd1;
    localparam logic [3:0] KW_AX    = 4'd2;
    localparam logic [3:0] KW_AXI   = 4'd3;
    localparam logic [3:0] KW_AXIS  = 4'd4;
    localparam logic [3:0] KW_B     = 4'd5;
    localparam logic [3:0] KW_BT    = 4'd6;
    localparam logic [3:0] KW_BTN   = 4'd7;
    localparam logic [3:0] KW_FAIL  = 4'd8;

    // number reader phases
    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // pressed field progress
    localparam logic [1:0] PR_NONE     = 2'd0;
    localparam logic [1:0] PR_PRESSED  = 2'd1;
    localparam logic [1:0] PR_RELEASED = 2'd2;

    // result outcome codes
    localparam logic [1:0] OUT_AXIS    = 2'd0;
    localparam logic [1:0] OUT_BUTTON  = 2'd1;
    localparam logic [1:0] OUT_IGNORED = 2'd2;

    // command queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one classified line, handed from front to back
    typedef struct packed {
        logic [1:0] outcome;   // what the back applies
        logic [7:0] first;     // left-right byte or button index
        logic [7:0] second;    // up-down byte
        logic       pressed;   // new button state
    } cmd_t;

endpackage

`default_nettype wire

[sv/gamepad_line_command_parser_unit.sv]
// top level of the gamepad line command parser
// depends on gpcp_pkg, gpcp_front, gpcp_queue, gpcp_back and the assertion header
`default_nettype none

`include "gamepad_line_command_parser_unit_assert.svh"

// Takes one serial character per transfer on the s_ side and emits one result per
// non-empty line (on its newline) on the m_ side. Every character, newline
// included, is taken while s_tready is high: the front end updates its line parse
// state each cycle and, at a newline, pushes a classified command into a
// four-entry queue. The back end applies one command per cycle while its result
// register is free or being drained, updating the axis and button registers, and
// holds the result in that output register, so the input keeps flowing while a
// result waits. s_tready falls only when the queue is full, which needs four
// finished lines queued behind a result held by a stalled m_ side. m_tvalid rises
// when a queued command is loaded into the result register. No clearing pass.

module gamepad_line_command_parser_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] char_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata     // [1:0] outcome, [9:2] lr_axis, [17:10] ud_axis,
                                         // [25:18] button_mask, [31:26] zero
);

    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    gpcp_pkg::cmd_t push_cmd;
    gpcp_pkg::cmd_t pop_cmd;

    // character parser
    gpcp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // command queue
    gpcp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    // command executor and result register
    gpcp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .pop_cmd  (pop_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // only a newline transfer may queue a command
    `GPCP_ASSERT(a_push_on_newline, push |-> (s_tvalid && s_tready && (s_tdata == gpcp_pkg::CH_NL)), "command queued without newline transfer")

    // queue never written while full
    `GPCP_ASSERT(a_no_overflow, push |-> !full, "command queue overflow")

    // queue never read while empty
    `GPCP_ASSERT_ALWAYS(a_no_underflow, pop |-> !empty, "command queue underflow")

endmodule

`default_nettype wire

[sv/gpcp_front.sv]
// front end: takes characters, tracks the line being parsed, classifies it at newline
// depends on gpcp_pkg
`default_nettype none

module gpcp_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,      // [7:0] char_in
    input  wire logic          queue_full,
    output logic               push,
    output gpcp_pkg::cmd_t     push_cmd
);

    logic [gpcp_pkg::LINE_CNT_W-1:0] line_count_reg, line_count_next;
    logic       text_ended_reg, text_ended_next;
    logic [2:0] field_reg, field_next;
    logic [3:0] kw_reg, kw_next;
    logic [1:0] phase_reg, phase_next;
    logic       neg_reg, neg_next;
    logic [15:0] accum_reg, accum_next;
    logic [7:0] first_reg, first_next;
    logic       first_bad_reg, first_bad_next;
    logic [1:0] pressed_reg, pressed_next;

    logic        accept;
    logic [7:0]  c;
    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit;
    logic [11:0] t_lo;
    logic [11:0] t_hi;
    logic [15:0] accum_dig;
    logic [7:0]  num_byte;
    logic [7:0]  num_index;
    logic        num_index_bad;
    logic        feed_number;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;

    // character classes
    assign is_digit = (c >= gpcp_pkg::CH_ZERO) && (c <= gpcp_pkg::CH_NINE);
    assign is_space = (c == gpcp_pkg::CH_SPACE) ||
                      ((c >= gpcp_pkg::CH_TAB) && (c <= gpcp_pkg::CH_CR));
    assign digit    = 4'(c - gpcp_pkg::CH_ZERO);

    // one decimal digit step: exact low byte, saturated high byte
    assign t_lo = 12'(accum_reg[7:0]) * 12'd10 + 12'(digit);
    assign t_hi = 12'(accum_reg[15:8]) * 12'd10 + 12'(t_lo[11:8]);
    assign accum_dig = {(t_hi > 12'd255) ? 8'hFF : t_hi[7:0], t_lo[7:0]};

    // value of the number read so far
    assign num_byte = neg_reg ? 8'(8'd0 - accum_reg[7:0]) : accum_reg[7:0];
    always_comb begin
        num_index     = 8'd0;
        num_index_bad = 1'b0;
        if (accum_reg != 16'd0) begin
            if (!neg_reg && (accum_reg[15:8] == 8'd0) &&
                (32'(accum_reg[7:0]) < gpcp_pkg::BUTTON_COUNT)) begin
                num_index = accum_reg[7:0];
            end else begin
                num_index_bad = 1'b1;
            end
        end
    end

    // classify the finished line
    always_comb begin
        push_cmd.outcome = gpcp_pkg::OUT_IGNORED;
        push_cmd.first   = first_reg;
        push_cmd.second  = num_byte;
        push_cmd.pressed = (pressed_reg == gpcp_pkg::PR_PRESSED);
        if ((kw_reg == gpcp_pkg::KW_AXIS) && (field_reg >= 3'd3)) begin
            push_cmd.outcome = gpcp_pkg::OUT_AXIS;
        end else if ((kw_reg == gpcp_pkg::KW_BTN) && (field_reg >= 3'd2) &&
                     !first_bad_reg) begin
            push_cmd.outcome = gpcp_pkg::OUT_BUTTON;
        end
    end

    assign push = accept && (c == gpcp_pkg::CH_NL) && (line_count_reg != '0);

    // number field routing
    always_comb begin
        feed_number = 1'b0;
        if (field_reg != 3'd0) begin
            if (kw_reg == gpcp_pkg::KW_AXIS) begin
                feed_number = (field_reg == 3'd2) || (field_reg == 3'd3);
            end else if (kw_reg == gpcp_pkg::KW_BTN) begin
                feed_number = (field_reg == 3'd1);
            end
        end
    end

    // per-character parse step
    always_comb begin
        line_count_next = line_count_reg;
        text_ended_next = text_ended_reg;
        field_next      = field_reg;
        kw_next         = kw_reg;
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        accum_next      = accum_reg;
        first_next      = first_reg;
        first_bad_next  = first_bad_reg;
        pressed_next    = pressed_reg;
        if (accept) begin
            if (c == gpcp_pkg::CH_NL) begin
                line_count_next = '0;
                text_ended_next = 1'b0;
                field_next      = 3'd0;
                kw_next         = gpcp_pkg::KW_START;
                phase_next      = gpcp_pkg::PH_SKIP;
                neg_next        = 1'b0;
                accum_next      = 16'd0;
                first_next      = 8'd0;
                first_bad_next  = 1'b0;
                pressed_next    = gpcp_pkg::PR_NONE;
            end else if (32'(line_count_reg) < gpcp_pkg::MAX_LINE) begin
                line_count_next = line_count_reg + 1'b1;
                if (text_ended_reg) begin
                    // rest of the line is past a zero byte
                end else if (c == gpcp_pkg::CH_NUL) begin
                    text_ended_next = 1'b1;
                end else if (c == gpcp_pkg::CH_COLON) begin
                    if ((field_reg == 3'd0) && (kw_reg != gpcp_pkg::KW_AXIS) &&
                        (kw_reg != gpcp_pkg::KW_BTN)) begin
                        kw_next = gpcp_pkg::KW_FAIL;
                    end
                    if ((kw_reg == gpcp_pkg::KW_AXIS) && (field_reg == 3'd2)) begin
                        first_next = num_byte;
                    end
                    if ((kw_reg == gpcp_pkg::KW_BTN) && (field_reg == 3'd1)) begin
                        first_next     = num_index;
                        first_bad_next = num_index_bad;
                    end
                    if (field_reg < 3'd4) begin
                        field_next = field_reg + 3'd1;
                    end
                    if (field_reg <= 3'd2) begin
                        phase_next = gpcp_pkg::PH_SKIP;
                        neg_next   = 1'b0;
                        accum_next = 16'd0;
                    end
                end else if (field_reg == 3'd0) begin
                    // keyword compare
                    kw_next = gpcp_pkg::KW_FAIL;
                    if ((kw_reg == gpcp_pkg::KW_START) && (c == gpcp_pkg::CH_A)) begin
                        kw_next = gpcp_pkg::KW_A;
                    end else if ((kw_reg == gpcp_pkg::KW_START) && (c == gpcp_pkg::CH_B)) begin
                        kw_next = gpcp_pkg::KW_B;
                    end else if ((kw_reg == gpcp_pkg::KW_A) && (c == gpcp_pkg::CH_X)) begin
                        kw_next = gpcp_pkg::KW_AX;
                    end else if ((kw_reg == gpcp_pkg::KW_AX) && (c == gpcp_pkg::CH_I)) begin
                        kw_next = gpcp_pkg::KW_AXI;
                    end else if ((kw_reg == gpcp_pkg::KW_AXI) && (c == gpcp_pkg::CH_S)) begin
                        kw_next = gpcp_pkg::KW_AXIS;
                    end else if ((kw_reg == gpcp_pkg::KW_B) && (c == gpcp_pkg::CH_T)) begin
                        kw_next = gpcp_pkg::KW_BT;
                    end else if ((kw_reg == gpcp_pkg::KW_BT) && (c == gpcp_pkg::CH_N)) begin
                        kw_next = gpcp_pkg::KW_BTN;
                    end
                end else if (feed_number) begin
                    // atoi-style number reader
                    if (phase_reg == gpcp_pkg::PH_SKIP) begin
                        if (is_space) begin
                            phase_next = phase_reg;
                        end else if ((c == gpcp_pkg::CH_PLUS) || (c == gpcp_pkg::CH_MINUS)) begin
                            neg_next   = (c == gpcp_pkg::CH_MINUS);
                            phase_next = gpcp_pkg::PH_DIGITS;
                        end else if (is_digit) begin
                            accum_next = accum_dig;
                            phase_next = gpcp_pkg::PH_DIGITS;
                        end else begin
                            phase_next = gpcp_pkg::PH_DONE;
                        end
                    end else if (phase_reg == gpcp_pkg::PH_DIGITS) begin
                        if (is_digit) begin
                            accum_next = accum_dig;
                        end else begin
                            phase_next = gpcp_pkg::PH_DONE;
                        end
                    end
                end else if ((kw_reg == gpcp_pkg::KW_BTN) && (field_reg == 3'd2) &&
                             (pressed_reg == gpcp_pkg::PR_NONE)) begin
                    pressed_next = (c == gpcp_pkg::CH_ONE) ? gpcp_pkg::PR_PRESSED
                                                           : gpcp_pkg::PR_RELEASED;
                end
            end
        end
    end

    // line state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg <= '0;
            text_ended_reg <= 1'b0;
            field_reg      <= 3'd0;
            kw_reg         <= gpcp_pkg::KW_START;
            phase_reg      <= gpcp_pkg::PH_SKIP;
            neg_reg        <= 1'b0;
            accum_reg      <= 16'd0;
            first_reg      <= 8'd0;
            first_bad_reg  <= 1'b0;
            pressed_reg    <= gpcp_pkg::PR_NONE;
        end else begin
            line_count_reg <= line_count_next;
            text_ended_reg <= text_ended_next;
            field_reg      <= field_next;
            kw_reg         <= kw_next;
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            accum_reg      <= accum_next;
            first_reg      <= first_next;
            first_bad_reg  <= first_bad_next;
            pressed_reg    <= pressed_next;
        end
    end

endmodule

`default_nettype wire

[sv/gpcp_queue.sv]
// short command queue between front and back
// depends on gpcp_pkg
`default_nettype none

module gpcp_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire gpcp_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output gpcp_pkg::cmd_t      pop_cmd,
    output logic                empty
);

    gpcp_pkg::cmd_t mem [gpcp_pkg::QUEUE_DEPTH];

    logic [gpcp_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gpcp_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gpcp_pkg::QUEUE_AW:0]   count_reg, count_next;

    assign full    = (32'(count_reg) == gpcp_pkg::QUEUE_DEPTH);
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[sv/gpcp_back.sv]
// back end: applies queued commands to the pad state and drives the result register
// depends on gpcp_pkg
`default_nettype none

module gpcp_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           empty,
    input  wire gpcp_pkg::cmd_t pop_cmd,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [31:0]         m_tdata   // [1:0] outcome, [9:2] lr_axis, [17:10] ud_axis,
                                          // [25:18] button_mask, [31:26] zero
);

    logic [7:0] axis_lr_reg, axis_lr_next;
    logic [7:0] axis_ud_reg, axis_ud_next;
    logic [gpcp_pkg::BUTTON_COUNT-1:0] buttons_reg, buttons_next;
    logic       m_valid_reg;
    logic [1:0] outcome_reg;
    logic [7:0] out_mask;
    logic [gpcp_pkg::BTN_IDX_W-1:0] btn_idx;

    // take a command when the result slot is free or being drained
    assign pop     = !empty && (!m_valid_reg || m_tready);
    assign btn_idx = pop_cmd.first[gpcp_pkg::BTN_IDX_W-1:0];

    // pad state update
    always_comb begin
        axis_lr_next = axis_lr_reg;
        axis_ud_next = axis_ud_reg;
        buttons_next = buttons_reg;
        unique case (pop_cmd.outcome)
            gpcp_pkg::OUT_AXIS: begin
                axis_lr_next = pop_cmd.first;
                axis_ud_next = pop_cmd.second;
            end
            gpcp_pkg::OUT_BUTTON: begin
                buttons_next[btn_idx] = pop_cmd.pressed;
            end
            default: begin
                axis_lr_next = axis_lr_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_lr_reg <= 8'd0;
            axis_ud_reg <= 8'd0;
            buttons_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                axis_lr_reg <= axis_lr_next;
                axis_ud_reg <= axis_ud_next;
                buttons_reg <= buttons_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // outcome of the held result
    always_ff @(posedge aclk) begin
        if (pop) begin
            outcome_reg <= pop_cmd.outcome;
        end
    end

    // low eight buttons form the reported mask
    always_comb begin
        out_mask = 8'd0;
        for (int i = 0; i < 8; i++) begin
            if (i < int'(gpcp_pkg::BUTTON_COUNT)) begin
                out_mask[i] = buttons_reg[i];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, out_mask, axis_ud_reg, axis_lr_reg, outcome_reg};

endmodule

`default_nettype wire
